// File: rtl/core/gso_pkg.sv
// package for the modified gram-schmidt core: sizes, serial unit op codes, shared types
// no dependencies
package gso_pkg;
   localparam int NUM_VECTORS_DEF   = 32;
   localparam int VECTOR_LENGTH_DEF = 2;
   localparam int ElemW  = 16;
   localparam int EpsW   = 16;
   localparam int AccW   = 64;
   localparam logic [EpsW-1:0] EPS_RESET = 16'd1;

   // serial unit operations
   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_SQRT = 2'd1;
   localparam logic [1:0] OP_DIV  = 2'd2;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } su_ctl_type;
endpackage

// File: rtl/core/gso_serial_unit.sv
// shared bit-serial unit: 64x64 shift-add multiply, 64-bit integer root, 64/64 divide
// depends on gso_pkg
module gso_serial_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  gso_pkg::su_ctl_type    ctl,
   input  logic [63:0]            opa,
   input  logic [63:0]            opb,
   output logic                   done,
   output logic [63:0]            res
);
   import gso_pkg::*;

   logic        busy_ff, busy_in;
   logic [1:0]  op_ff, op_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] q_ff, q_in;
   logic        done_ff, done_in;
   logic [65:0] trial;
   logic [64:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      b_in    = b_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      trial   = '0;
      rem_sh  = '0;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = '0;
         b_in    = opb;
         q_in    = '0;
         case (ctl.op)
            OP_MUL:  acc_in = {64'd0, opa};
            OP_SQRT: acc_in = {64'd0, opa};
            OP_DIV:  acc_in = {64'd0, opa};
            default: acc_in = '0;
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               // acc lower holds multiplier bits, upper the sum
               if (acc_ff[0])
                  acc_in = {1'b0, acc_ff[127:1]} + {1'b0, b_ff, 63'd0};
               else
                  acc_in = {1'b0, acc_ff[127:1]};
            end
            OP_SQRT: begin
               // acc[63:0] remaining radicand, acc[127:64] remainder, q root
               rem_sh = {acc_ff[126:64], acc_ff[63:62]};
               trial  = {1'b0, rem_sh} - {q_ff, 2'b01};
               acc_in[63:0] = {acc_ff[61:0], 2'b00};
               if (!trial[65]) begin
                  acc_in[127:64] = trial[63:0];
                  q_in = {q_ff[62:0], 1'b1};
               end else begin
                  acc_in[127:64] = rem_sh[63:0];
                  q_in = {q_ff[62:0], 1'b0};
               end
            end
            OP_DIV: begin
               rem_sh = {acc_ff[127:64], acc_ff[63]};
               trial  = {1'b0, rem_sh} - {2'b00, b_ff};
               acc_in[63:0] = {acc_ff[62:0], 1'b0};
               if (!trial[65]) begin
                  acc_in[127:64] = trial[63:0];
                  q_in = {q_ff[62:0], 1'b1};
               end else begin
                  acc_in[127:64] = rem_sh[63:0];
                  q_in = {q_ff[62:0], 1'b0};
               end
            end
            default: acc_in = acc_ff;
         endcase
         cnt_in = cnt_ff + 7'd1;
         if ((op_ff == OP_SQRT && cnt_ff == 7'd31) || cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign res  = (op_ff == OP_MUL) ? acc_ff[63:0] : q_ff;
endmodule

// File: rtl/core/gram_schmidt_orthonormalizer_core.sv
// processing starts after the request marked last; requests are taken one per cycle
// only while in the load state (req_stall low); products, roots and divides run on one
// shared bit-serial unit; results stream out in order, each held while rsp_stall is high
// reset (synchronous) clears load count, sequencer and output valid; epsilon
// returns to 1; the matrix store holds garbage until loaded
// depends on gso_pkg and gso_serial_unit
module gram_schmidt_orthonormalizer_core #(
   parameter int NUM_VECTORS   = gso_pkg::NUM_VECTORS_DEF,
   parameter int VECTOR_LENGTH = gso_pkg::VECTOR_LENGTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_element_value,
   input  logic                req_element_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_result_value,
   output logic                rsp_result_last,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);
   import gso_pkg::*;

   localparam int MatSize = NUM_VECTORS * VECTOR_LENGTH;
   localparam int AW = (MatSize > 1) ? $clog2(MatSize) : 1;
   localparam int RW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
   localparam int KW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

   localparam logic [4:0] S_LOAD  = 5'd0;
   localparam logic [4:0] S_DRD_W = 5'd1;
   localparam logic [4:0] S_DRD_V = 5'd2;
   localparam logic [4:0] S_DMUL  = 5'd3;
   localparam logic [4:0] S_DWAIT = 5'd4;
   localparam logic [4:0] S_URD   = 5'd5;
   localparam logic [4:0] S_UMUL  = 5'd6;
   localparam logic [4:0] S_UWAIT = 5'd7;
   localparam logic [4:0] S_UWR   = 5'd8;
   localparam logic [4:0] S_NRD   = 5'd9;
   localparam logic [4:0] S_NMUL  = 5'd10;
   localparam logic [4:0] S_NWAIT = 5'd11;
   localparam logic [4:0] S_SQRT  = 5'd12;
   localparam logic [4:0] S_SWAIT = 5'd13;
   localparam logic [4:0] S_VRD   = 5'd14;
   localparam logic [4:0] S_VDIV  = 5'd15;
   localparam logic [4:0] S_VWAIT = 5'd16;
   localparam logic [4:0] S_VWR   = 5'd17;
   localparam logic [4:0] S_ORD   = 5'd18;
   localparam logic [4:0] S_OUT   = 5'd19;
   localparam logic [4:0] S_RDL   = 5'd20;

   logic signed [15:0] mem [MatSize];
   logic [15:0]  rd_ff;
   logic         rd_en;
   logic [AW-1:0] raddr;
   logic         we;
   logic [AW-1:0] waddr;
   logic [15:0]  wdata;

   logic [4:0]   st_ff, st_in;
   logic [AW-1:0] lc_ff, lc_in;
   logic [RW-1:0] i_ff, i_in, j_ff, j_in;
   logic [KW-1:0] k_ff, k_in;
   logic [AW-1:0] oa_ff, oa_in;
   logic [15:0]  eps_ff;
   logic [63:0]  acc_ff, acc_in;
   logic [63:0]  dot_ff, dot_in;
   logic [63:0]  r_ff, r_in;
   logic [15:0]  wv_ff, wv_in;
   logic [4:0]   ret_ff, ret_in;
   logic         ov_ff, ov_in;
   logic [15:0]  oval_ff, oval_in;
   logic         olast_ff, olast_in;

   su_ctl_type   su_ctl;
   logic [63:0]  su_a, su_b, su_res;
   logic         su_done;

   gso_serial_unit u_su (
      .clock (clock), .reset (reset), .ctl (su_ctl),
      .opa (su_a), .opb (su_b), .done (su_done), .res (su_res)
   );

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [KW-1:0] k);
      logic [AW+RW:0] t;
      t = (AW+RW+1)'(r) * (AW+RW+1)'(VECTOR_LENGTH) + (AW+RW+1)'(k);
      return t[AW-1:0];
   endfunction

   function automatic logic [15:0] sat16(input logic signed [65:0] v);
      if (v > 66'sd32767) return 16'h7fff;
      if (v < -66'sd32768) return 16'h8000;
      return v[15:0];
   endfunction

   logic [63:0] mag_a, mag_b;
   logic        neg_a;
   logic [63:0] sq_rnd, qsat;
   logic signed [65:0] upd;

   always_comb begin
      st_in   = st_ff;
      lc_in   = lc_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      oa_in   = oa_ff;
      acc_in  = acc_ff;
      dot_in  = dot_ff;
      r_in    = r_ff;
      wv_in   = wv_ff;
      ret_in  = ret_ff;
      ov_in   = ov_ff;
      oval_in = oval_ff;
      olast_in = olast_ff;
      su_ctl  = '0;
      su_a    = '0;
      su_b    = '0;
      raddr   = '0;
      rd_en   = 1'b0;
      we      = 1'b0;
      waddr   = '0;
      wdata   = '0;
      mag_a   = '0;
      mag_b   = '0;
      neg_a   = 1'b0;
      sq_rnd  = '0;
      qsat    = '0;
      upd     = '0;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      case (st_ff)
         S_LOAD: begin
            if (req_valid) begin
               we    = 1'b1;
               waddr = lc_ff;
               wdata = req_element_value;
               if (req_element_last) begin
                  lc_in = '0;
                  i_in  = '0;
                  j_in  = '0;
                  k_in  = '0;
                  acc_in = '0;
                  st_in = S_NRD;
               end else if (lc_ff == AW'(MatSize - 1)) begin
                  lc_in = '0;
               end else begin
                  lc_in = lc_ff + 1'b1;
               end
            end
         end
         // dot product w.v_j: read w[k]
         S_DRD_W: begin
            raddr = addr_of(i_ff, k_ff);
            rd_en = 1'b1;
            st_in = S_DRD_V;
         end
         S_DRD_V: begin
            raddr = addr_of(j_ff, k_ff);
            rd_en = 1'b1;
            wv_in = rd_ff;
            st_in = S_RDL;
            ret_in = S_DMUL;
         end
         S_RDL: st_in = ret_ff;
         S_DMUL: begin
            su_ctl.start = 1'b1;
            su_ctl.op    = OP_MUL;
            su_a = {{48{wv_ff[15]}}, wv_ff};
            su_b = {{48{rd_ff[15]}}, rd_ff};
            st_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (su_done) begin
               if (k_ff == KW'(VECTOR_LENGTH - 1)) begin
                  dot_in = acc_ff + su_res;
                  acc_in = '0;
                  k_in   = '0;
                  st_in  = S_URD;
               end else begin
                  acc_in = acc_ff + su_res;
                  k_in   = k_ff + 1'b1;
                  st_in  = S_DRD_W;
               end
            end
         end
         // update w[k] -= round(dot*v[k] >> 28)
         S_URD: begin
            raddr = addr_of(j_ff, k_ff);
            rd_en = 1'b1;
            st_in = S_RDL;
            ret_in = S_UMUL;
         end
         S_UMUL: begin
            su_ctl.start = 1'b1;
            su_ctl.op    = OP_MUL;
            su_a = dot_ff;
            su_b = {{48{rd_ff[15]}}, rd_ff};
            raddr = addr_of(i_ff, k_ff);
            rd_en = 1'b1;
            st_in = S_UWAIT;
         end
         S_UWAIT: begin
            raddr = addr_of(i_ff, k_ff);
            rd_en = 1'b1;
            if (su_done) begin
               neg_a  = su_res[63];
               mag_a  = neg_a ? (64'd0 - su_res) : su_res;
               mag_b  = (mag_a + 64'd134217728) >> 28;
               acc_in = neg_a ? (64'd0 - mag_b) : mag_b;
               st_in  = S_UWR;
            end
         end
         S_UWR: begin
            upd   = 66'(signed'(rd_ff)) - 66'(signed'(acc_ff));
            we    = 1'b1;
            waddr = addr_of(i_ff, k_ff);
            wdata = sat16(upd);
            acc_in = '0;
            if (k_ff == KW'(VECTOR_LENGTH - 1)) begin
               k_in = '0;
               if (j_ff + 1'b1 == i_ff) begin
                  st_in = S_NRD;
               end else begin
                  j_in  = j_ff + 1'b1;
                  st_in = S_DRD_W;
               end
            end else begin
               k_in  = k_ff + 1'b1;
               st_in = S_URD;
            end
         end
         // squared norm
         S_NRD: begin
            raddr = addr_of(i_ff, k_ff);
            rd_en = 1'b1;
            st_in = S_RDL;
            ret_in = S_NMUL;
         end
         S_NMUL: begin
            su_ctl.start = 1'b1;
            su_ctl.op    = OP_MUL;
            su_a = {{48{rd_ff[15]}}, rd_ff};
            su_b = {{48{rd_ff[15]}}, rd_ff};
            st_in = S_NWAIT;
         end
         S_NWAIT: begin
            if (su_done) begin
               acc_in = acc_ff + su_res;
               if (k_ff == KW'(VECTOR_LENGTH - 1)) begin
                  k_in  = '0;
                  st_in = S_SQRT;
               end else begin
                  k_in  = k_ff + 1'b1;
                  st_in = S_NRD;
               end
            end
         end
         S_SQRT: begin
            su_ctl.start = 1'b1;
            su_ctl.op    = OP_SQRT;
            su_a = (acc_ff + {48'd0, eps_ff}) << 28;
            st_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (su_done) begin
               r_in   = su_res;
               acc_in = '0;
               st_in  = S_VRD;
            end
         end
         // normalise w[k]
         S_VRD: begin
            raddr = addr_of(i_ff, k_ff);
            rd_en = 1'b1;
            st_in = S_RDL;
            ret_in = S_VDIV;
         end
         S_VDIV: begin
            neg_a = rd_ff[15];
            mag_a = neg_a ? (64'd0 - {{48{rd_ff[15]}}, rd_ff}) : {48'd0, rd_ff};
            wv_in = rd_ff;
            su_ctl.start = 1'b1;
            su_ctl.op    = OP_DIV;
            su_a = (mag_a << 28) + (r_ff >> 1);
            su_b = r_ff;
            st_in = (r_ff == '0) ? S_VWR : S_VWAIT;
         end
         S_VWAIT: begin
            if (su_done) st_in = S_VWR;
         end
         S_VWR: begin
            we    = 1'b1;
            waddr = addr_of(i_ff, k_ff);
            qsat  = (su_res > 64'd32768) ? 64'd32768 : su_res;
            sq_rnd = wv_ff[15] ? (64'd0 - qsat) : qsat;
            if (r_ff == '0) wdata = '0;
            else wdata = sat16(66'(signed'(sq_rnd)));
            if (k_ff == KW'(VECTOR_LENGTH - 1)) begin
               k_in = '0;
               j_in = '0;
               if (i_ff == RW'(NUM_VECTORS - 1)) begin
                  oa_in = '0;
                  st_in = S_ORD;
               end else begin
                  i_in  = i_ff + 1'b1;
                  st_in = S_DRD_W;
               end
            end else begin
               k_in  = k_ff + 1'b1;
               st_in = S_VRD;
            end
         end
         // stream out
         S_ORD: begin
            raddr = oa_ff;
            rd_en = 1'b1;
            if (!ov_ff || !rsp_stall) st_in = S_OUT;
         end
         S_OUT: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in    = 1'b1;
               oval_in  = rd_ff;
               olast_in = (oa_ff == AW'(MatSize - 1));
               if (oa_ff == AW'(MatSize - 1)) begin
                  st_in = S_LOAD;
               end else begin
                  oa_in = oa_ff + 1'b1;
                  st_in = S_ORD;
               end
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   assign req_stall = (st_ff != S_LOAD);

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rd_en) rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_LOAD;
         lc_ff  <= '0;
         ov_ff  <= 1'b0;
         eps_ff <= EPS_RESET;
      end else begin
         st_ff <= st_in;
         lc_ff <= lc_in;
         ov_ff <= ov_in;
         if (csr_wr_en) eps_ff <= csr_wr_data;
      end
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      oa_ff <= oa_in;
      acc_ff <= acc_in;
      dot_ff <= dot_in;
      r_ff  <= r_in;
      wv_ff <= wv_in;
      ret_ff <= ret_in;
      oval_ff <= oval_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_result_value = oval_ff;
   assign rsp_result_last  = olast_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_LOAD) |-> req_stall)
      else $error("request taken while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_value)))
      else $error("result changed under stall");
   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_OUT && rsp_valid && rsp_stall) |=> (st_ff == S_OUT))
      else $error("output step left while result stalled");
`endif
endmodule
